@@ hdl/cow_ovl_pkg.sv @@
`default_nettype none
package cow_ovl_pkg;

   localparam int unsigned SectorsPerPage = 8;
   localparam int unsigned OffW           = $clog2(SectorsPerPage);
   localparam int unsigned MaxPages       = 4096;
   localparam int unsigned SlotW          = $clog2(MaxPages);
   localparam int unsigned Buckets        = 256;
   localparam int unsigned HashW          = $clog2(Buckets);
   localparam int unsigned TagW           = 32 - OffW;

   localparam logic [1:0] StOk    = 2'd0;
   localparam logic [1:0] StNoDev = 2'd1;
   localparam logic [1:0] StIoErr = 2'd2;

   // result kinds the controller asks the datapath to emit
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_NODEV,
      EMIT_IOERR,
      EMIT_BASE,
      EMIT_HIT,
      EMIT_FRESH
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     rd_head;
      logic     rd_first;
      logic     rd_next;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic zero_count;
      logic range_err;
      logic head_valid;
      logic tag_match;
      logic next_valid;
      logic full;
      logic out_free;
      logic last_seg;
   } stat_type;

endpackage
`default_nettype wire

@@ hdl/cow_ovl_dp.sv @@
`default_nettype none
module cow_ovl_dp import cow_ovl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_lba,
   input  wire logic [7:0]  req_count,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic        rsp_tready,
   output logic             rsp_tvalid,
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic [31:0] ps_ff;
   logic        wr_ff;
   logic [31:0] lba_ff;
   logic [31:0] cur_ff, cur_in;
   logic [7:0]  rem_ff, rem_in;
   logic [SlotW:0] used_ff;

   logic [SlotW-1:0] head_mem [Buckets];
   logic [Buckets-1:0] head_vld_ff;
   logic [TagW-1:0]  tag_mem [MaxPages];
   logic [SlotW:0]   nxt_mem [MaxPages];

   logic [SlotW-1:0] head_q_ff;
   logic             head_v_ff;
   logic [TagW-1:0]  tag_q_ff;
   logic [SlotW:0]   nxt_q_ff;
   logic [SlotW-1:0] ptr_ff;

   logic            out_vld_ff;
   logic [31:0]     o_lba_ff;
   logic [3:0]      o_secs_ff;
   logic [OffW-1:0] o_off_ff;
   logic            o_ovl_ff;
   logic [SlotW-1:0] o_slot_ff;
   logic            o_fresh_ff;
   logic [3:0]      o_fill_ff;
   logic [1:0]      o_status_ff;
   logic            o_last_ff;

   logic [OffW-1:0]  off;
   logic [TagW-1:0]  tag;
   logic [HashW-1:0] hash;
   logic [3:0]       room;
   logic [3:0]       secs;
   logic [31:0]      diff;
   logic [31:0]      avail;
   logic [3:0]       fill;
   logic [SlotW-1:0] rd_addr;
   logic             seg_emit;
   logic             alloc;

   assign off  = cur_ff[OffW-1:0];
   assign tag  = cur_ff[31:OffW];
   assign hash = tag[HashW-1:0];
   assign room = 4'(SectorsPerPage) - {1'b0, off};
   assign secs = (rem_ff < {4'b0, room}) ? rem_ff[3:0] : room;
   assign diff = ps_ff - lba_ff;
   assign avail = ps_ff - {tag, {OffW{1'b0}}};
   assign fill = (avail < 32'(SectorsPerPage)) ? avail[3:0] : 4'(SectorsPerPage);
   assign rd_addr = cmd.rd_first ? head_q_ff : nxt_q_ff[SlotW-1:0];
   assign seg_emit = (cmd.emit == EMIT_BASE) || (cmd.emit == EMIT_HIT) ||
                     (cmd.emit == EMIT_FRESH);
   assign alloc = (cmd.emit == EMIT_FRESH);
   assign cur_in = cur_ff + {28'b0, secs};
   assign rem_in = rem_ff - {4'b0, secs};

   always_comb begin
      stat.is_write   = wr_ff;
      stat.zero_count = (rem_ff == 8'd0);
      stat.range_err  = (lba_ff >= ps_ff) || ({24'b0, rem_ff} > diff);
      stat.head_valid = head_v_ff;
      stat.tag_match  = (tag_q_ff == tag);
      stat.next_valid = nxt_q_ff[SlotW];
      stat.full       = (used_ff == (SlotW+1)'(MaxPages));
      stat.out_free   = !out_vld_ff || rsp_tready;
      stat.last_seg   = (rem_ff == {4'b0, secs});
   end

   // overlay tables
   always_ff @(posedge clock) begin
      if (cmd.rd_head) begin
         head_q_ff <= head_mem[hash];
      end
      if (cmd.rd_first || cmd.rd_next) begin
         tag_q_ff <= tag_mem[rd_addr];
         nxt_q_ff <= nxt_mem[rd_addr];
         ptr_ff   <= rd_addr;
      end
      if (alloc) begin
         tag_mem[used_ff[SlotW-1:0]] <= tag;
         nxt_mem[used_ff[SlotW-1:0]] <= {head_v_ff, head_q_ff};
         head_mem[hash]              <= used_ff[SlotW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff       <= '0;
         used_ff     <= '0;
         head_vld_ff <= '0;
         head_v_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            ps_ff <= csr_wdata;
         end
         if (cmd.rd_head) begin
            head_v_ff <= head_vld_ff[hash];
         end
         if (alloc) begin
            head_vld_ff[hash] <= 1'b1;
            used_ff           <= used_ff + 1'b1;
         end
         if (cmd.emit != EMIT_NONE) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wr_ff  <= req_cmd;
         lba_ff <= req_lba;
         cur_ff <= req_lba;
         rem_ff <= req_count;
      end else if (seg_emit) begin
         cur_ff <= cur_in;
         rem_ff <= rem_in;
      end
      if (cmd.emit != EMIT_NONE) begin
         o_lba_ff    <= seg_emit ? cur_ff : lba_ff;
         o_secs_ff   <= seg_emit ? secs : 4'd0;
         o_off_ff    <= seg_emit ? off : '0;
         o_ovl_ff    <= (cmd.emit == EMIT_HIT) || alloc;
         o_slot_ff   <= (cmd.emit == EMIT_HIT) ? ptr_ff :
                        alloc ? used_ff[SlotW-1:0] : '0;
         o_fresh_ff  <= alloc;
         o_fill_ff   <= alloc ? fill : 4'd0;
         o_status_ff <= (cmd.emit == EMIT_NODEV) ? StNoDev :
                        (cmd.emit == EMIT_IOERR) ? StIoErr : StOk;
         o_last_ff   <= seg_emit ? stat.last_seg : 1'b1;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {5'b0, o_status_ff, o_fill_ff, o_fresh_ff, o_slot_ff, o_ovl_ff,
                        o_off_ff, o_secs_ff, o_lba_ff};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (SlotW+1)'(MaxPages))
      else $error("slot count beyond table size");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(used_ff) |-> (used_ff == $past(used_ff) + 1'b1) && $past(alloc))
      else $error("slot count moved without allocation");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> stat.out_free)
      else $error("result overwritten before taken");
   a_fresh_ovl: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && o_fresh_ff |-> o_ovl_ff && (o_status_ff == StOk))
      else $error("fresh slot without overlay");

endmodule
`default_nettype wire

@@ hdl/cow_ovl_ctrl.sv @@
`default_nettype none
module cow_ovl_ctrl import cow_ovl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_HEAD, S_HCHK, S_TCHK, S_MISS, S_ERR
   } state_type;

   state_type state_ff, state_in;
   logic      err_io_ff, err_io_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      err_io_in = err_io_ff;
      cmd       = '{load: 1'b0, rd_head: 1'b0, rd_first: 1'b0, rd_next: 1'b0,
                    emit: EMIT_NONE};
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.zero_count) begin
               err_io_in = 1'b0;
               state_in  = S_ERR;
            end else if (stat.range_err) begin
               err_io_in = 1'b1;
               state_in  = S_ERR;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = S_HCHK;
         end
         S_HCHK: begin
            if (stat.head_valid) begin
               cmd.rd_first = 1'b1;
               state_in     = S_TCHK;
            end else begin
               state_in = S_MISS;
            end
         end
         S_TCHK: begin
            if (stat.tag_match) begin
               if (stat.out_free) begin
                  cmd.emit = EMIT_HIT;
                  state_in = stat.last_seg ? S_IDLE : S_HEAD;
               end
            end else if (stat.next_valid) begin
               cmd.rd_next = 1'b1;
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (stat.is_write && stat.full) begin
               err_io_in = 1'b1;
               state_in  = S_ERR;
            end else if (stat.out_free) begin
               cmd.emit = stat.is_write ? EMIT_FRESH : EMIT_BASE;
               state_in = stat.last_seg ? S_IDLE : S_HEAD;
            end
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.emit = err_io_ff ? EMIT_IOERR : EMIT_NODEV;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         err_io_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         err_io_ff <= err_io_in;
      end
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CHECK)
      else $error("load outside idle");
   a_one_read: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rd_head, cmd.rd_first, cmd.rd_next, cmd.emit != EMIT_NONE}))
      else $error("conflicting commands");
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EMIT_IOERR || cmd.emit == EMIT_NODEV) |=> state_ff == S_IDLE)
      else $error("error result not final");

endmodule
`default_nettype wire

@@ hdl/copy_on_write_sector_overlay_map.sv @@
// steps: a request is accepted in idle and range-checked; a failed check registers a
// status-only result; otherwise each page segment reads its bucket head (256 buckets),
// compares the first chain entry and walks on one entry per failed tag compare
// throughput: one request at a time; a request touches up to 33 pages, one result per page,
// and each result is registered only once the result register is free
// reset: synchronous active high; clears slot count, bucket valid bits and size
`default_nettype none
module copy_on_write_sector_overlay_map import cow_ovl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // partition size in sectors
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // lba[31:0], num_sectors[39:32]
   input  wire logic        req_tuser,   // cmd: 0 read, 1 write
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // seg_lba[31:0], seg_sectors[35:32], seg_offset[38:36], from_overlay[39],
   // slot[51:40], fresh[52], fill_sectors[56:53], status[58:57], zeros above
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tlast    // last result of the request
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: range check, bucket lookup, chain walk, allocate, emit
   cow_ovl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // request registers, bucket heads, tag and chain memories, result register
   cow_ovl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_cmd    (req_tuser),
      .req_lba    (req_tdata[31:0]),
      .req_count  (req_tdata[39:32]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
